[src/ita_pkg.sv]
`default_nettype none

package ita_pkg;

  // Default width of the integer being converted.
  localparam int unsigned DefaultValueWidth = 32;

  // Width of one digit (radix up to 36).
  localparam int unsigned DigitW = 6;

  // Radix limits and the one radix that shows a sign.
  localparam logic [DigitW-1:0] RadixMin = 6'd2;
  localparam logic [DigitW-1:0] RadixMax = 6'd36;
  localparam logic [DigitW-1:0] RadixDec = 6'd10;

  // Character codes.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DigitW-1:0] rem;
  } div_status_t;

  // Map a digit value to its lower-case character.
  function automatic logic [7:0] digit_to_char(input logic [DigitW-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d > 6'd9) begin
      digit_to_char = CharA + (d8 - 8'd10);
    end else begin
      digit_to_char = CharZero + d8;
    end
  endfunction

endpackage

`default_nettype wire

[src/ita_div.sv]
`default_nettype none

// Restoring divider: one quotient bit per cycle, small divisor.
module ita_div
  import ita_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [DigitW-1:0]      divisor_i,
  output      logic [VALUE_WIDTH-1:0] quotient_o,
  output      div_status_t            status_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [DigitW-1:0]      rem_q, rem_d;
  logic [DigitW-1:0]      dvs_q, dvs_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DigitW:0]        trial;
  logic                   take;

  // One shift-and-subtract step.
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign take  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (take) begin
        rem_d = DigitW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DigitW-1:0];
      end
      quo_d = {quo_q[VALUE_WIDTH-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath words are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.rem  = rem_q;

endmodule

`default_nettype wire

[src/integer_to_ascii_radix.sv]
// Integer to ASCII text converter, radix 2 to 36.
// Input stream: one word per number, tdata holds value in the low VALUE_WIDTH
// bits and the radix in the next six bits. A radix outside 2..36 is clamped.
// Output stream: one word per character, tdata[7:0] is the character
// ('0'-'9', 'a'-'z' or '-'), tlast marks the final character of the number.
// A minus sign is shown only for negative values in radix ten; in other radices
// the value is read as unsigned. Zero gives the single character '0'.
// Digits come from a shared restoring divider that runs once per digit; the
// digit store is then drained, a minus sign first if there is one, each digit
// passing a read state and then an emit state, and the drain waits while the
// receiver stalls.
// The input is ready only while the converter is idle; one number is in
// flight at a time. When the receiver stalls, the output register holds its
// word and the sequencer waits. Reset clears the sequencer and the output
// valid; the digit store is not cleared, every entry is written before read.
`default_nettype none

module integer_to_ascii_radix
  import ita_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid_i,
  output      logic                                    s_axis_tready_o,
  // Fields from bit 0 up: value, radix, zero fill.
  input  wire logic [((VALUE_WIDTH+DigitW+7)/8)*8-1:0] s_axis_tdata_i,
  output      logic                                    m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i,
  // Fields from bit 0 up: ascii_char.
  output      logic [7:0]                              m_axis_tdata_o,
  output      logic                                    m_axis_tlast_o
);

  localparam int unsigned IdxW = $clog2(VALUE_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_READ = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DigitW-1:0]      radix_q, radix_d;
  logic                   neg_q, neg_d;
  logic                   start_q, start_d;
  logic [IdxW-1:0]        wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic [DigitW-1:0]      rd_data_q;
  logic [DigitW-1:0]      digit_mem [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0] in_value;
  logic [DigitW-1:0]      in_radix;
  logic [DigitW-1:0]      radix_clamped;
  logic                   in_neg;
  logic                   out_free;
  logic                   accept;
  logic [VALUE_WIDTH-1:0] div_quot;
  div_status_t            div_stat;

  // Unpack the input word and clamp the radix.
  assign in_value = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_radix = s_axis_tdata_i[VALUE_WIDTH+DigitW-1:VALUE_WIDTH];

  always_comb begin
    priority if (in_radix < RadixMin) begin
      radix_clamped = RadixMin;
    end else if (in_radix > RadixMax) begin
      radix_clamped = RadixMax;
    end else begin
      radix_clamped = in_radix;
    end
  end

  assign in_neg   = in_value[VALUE_WIDTH-1] && (radix_clamped == RadixDec);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Shared divider producing one digit per run.
  ita_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (quot_q),
    .divisor_i  (radix_q),
    .quotient_o (div_quot),
    .status_o   (div_stat)
  );

  // Sequencer: divide until the quotient is zero, then drain the digits.
  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    start_d     = 1'b0;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          quot_d   = in_neg ? (~in_value + 1'b1) : in_value;
          radix_d  = radix_clamped;
          neg_d    = in_neg;
          start_d  = 1'b1;
          wr_idx_d = '0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          quot_d   = div_quot;
          wr_idx_d = wr_idx_q + 1'b1;
          if (div_quot == '0) begin
            rd_idx_d = wr_idx_q;
            state_d  = neg_q ? S_SIGN : S_READ;
          end else begin
            start_d = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
          out_last_d  = 1'b0;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_to_char(rd_data_q);
          out_last_d  = (rd_idx_q == '0);
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      start_q     <= 1'b0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      quot_q      <= '0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      start_q     <= start_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      quot_q      <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Digit store, least significant digit first, registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_stat.done) begin
      digit_mem[wr_idx_q] <= div_stat.rem;
    end
    rd_data_q <= digit_mem[rd_idx_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  // The divider only runs while the sequencer is in the divide phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_DIV))
    else $error("divider busy outside the divide phase");

  // A minus sign is only emitted for a negative decimal number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN) |-> (neg_q && radix_q == RadixDec))
    else $error("sign phase entered for a non-negative or non-decimal number");

  // The final character returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && rd_idx_q == '0) |=>
      (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("last character did not end the number");
`endif

endmodule

`default_nettype wire
